// ===== hdl/dmc_pkg.sv =====
// Types, constants and message helpers for the distance-to-MIDI controller.
// Used by dmc_calc, dmc_serializer and distance_to_midi_controller_unit.
package dmc_pkg;

  localparam int unsigned RangeW = 8;
  localparam int unsigned ValW   = 7;
  localparam int unsigned DutyW  = 14;
  localparam int unsigned IdxW   = 4;

  localparam logic [ValW-1:0] ValMax      = 7'd127;
  localparam logic [ValW-1:0] NoteOffset  = 7'd10;
  localparam logic [ValW-1:0] NoteReset   = 7'd0;
  localparam logic [ValW-1:0] SentReset   = 7'd127;
  // x / 3 == (x * 171) >> 9 for every 8-bit x
  localparam logic [RangeW-1:0] Div3Mul   = 8'd171;
  localparam int unsigned       Div3Shift = 9;

  // MIDI bytes
  localparam logic [7:0] MidiCtrlChg  = 8'hB2;
  localparam logic [7:0] MidiAllOff   = 8'h7B;
  localparam logic [7:0] MidiZero     = 8'h00;
  localparam logic [7:0] MidiProgChg  = 8'hC2;
  localparam logic [7:0] MidiProgNum  = 8'h13;
  localparam logic [7:0] MidiNoteOn   = 8'h92;
  localparam logic [7:0] MidiMidVal   = 8'h40;
  localparam logic [7:0] MidiPitch    = 8'hE2;
  localparam logic [7:0] MidiVolMsb   = 8'h07;
  localparam logic [7:0] MidiVolLsb   = 8'h27;

  // Update offset in the start message, and last byte index per message kind
  localparam logic [IdxW-1:0] PosUpdate  = 4'd5;
  localparam logic [IdxW-1:0] LastNone   = 4'd0;
  localparam logic [IdxW-1:0] LastOff    = 4'd2;
  localparam logic [IdxW-1:0] LastStart  = 4'd12;
  localparam logic [IdxW-1:0] LastUpdate = 4'd7;

  typedef enum logic [1:0] {
    MSG_NONE,
    MSG_OFF,
    MSG_START,
    MSG_UPDATE
  } msg_kind_e;

  typedef struct packed {
    logic [RangeW-1:0] volume_range;
    logic              volume_error;
    logic [RangeW-1:0] pitch_range;
    logic              pitch_error;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       midi_byte;
    logic             byte_valid;
    logic             last_byte;
    logic [DutyW-1:0] pwm_duty;
  } out_item_t;

  typedef struct packed {
    msg_kind_e        kind;
    logic [ValW-1:0]  note;
    logic [ValW-1:0]  vol;
    logic [DutyW-1:0] duty;
  } msg_t;

  function automatic logic [IdxW-1:0] msg_last_idx(msg_kind_e kind);
    logic [IdxW-1:0] r;
    case (kind)
      MSG_NONE:   r = LastNone;
      MSG_OFF:    r = LastOff;
      MSG_START:  r = LastStart;
      MSG_UPDATE: r = LastUpdate;
      default:    r = LastNone;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] msg_byte(msg_kind_e kind, logic [IdxW-1:0] idx,
                                          logic [ValW-1:0] note, logic [ValW-1:0] vol);
    logic [IdxW-1:0] pos;
    logic [7:0]      b;
    // the update message is the tail of the start message
    pos = (kind == MSG_UPDATE) ? idx + PosUpdate : idx;
    b   = MidiZero;
    case (kind)
      MSG_OFF: begin
        case (idx)
          4'd0:    b = MidiCtrlChg;
          4'd1:    b = MidiAllOff;
          default: b = MidiZero;
        endcase
      end
      MSG_START, MSG_UPDATE: begin
        case (pos)
          4'd0:    b = MidiProgChg;
          4'd1:    b = MidiProgNum;
          4'd2:    b = MidiNoteOn;
          4'd3:    b = MidiMidVal;
          4'd4:    b = MidiMidVal;
          4'd5:    b = MidiPitch;
          4'd6:    b = {1'b0, note};
          4'd7:    b = {1'b0, note};
          4'd8:    b = MidiCtrlChg;
          4'd9:    b = MidiVolMsb;
          4'd10:   b = {1'b0, vol};
          4'd11:   b = MidiVolLsb;
          4'd12:   b = {1'b0, vol};
          default: b = MidiZero;
        endcase
      end
      default: b = MidiZero;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/dmc_calc.sv =====
// Volume/note computation and sent-state tracking; picks the message kind.
// Depends on dmc_pkg.
module dmc_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dmc_pkg::in_item_t item_i,
  output dmc_pkg::msg_t     msg_o
);

  logic [dmc_pkg::ValW-1:0] held_note_q, sent_note_q, sent_vol_q;

  logic [2*dmc_pkg::RangeW-1:0] vol_prod, pitch_prod;
  logic [dmc_pkg::ValW-1:0]     vol_q3, pitch_q3;
  logic [dmc_pkg::ValW:0]       note_sum;
  logic [dmc_pkg::ValW-1:0]     note_new, note, vol;
  logic                         changed;
  dmc_pkg::msg_kind_e           kind;

  always_comb begin
    vol_prod   = {{dmc_pkg::RangeW{1'b0}}, item_i.volume_range}
               * {{dmc_pkg::RangeW{1'b0}}, dmc_pkg::Div3Mul};
    pitch_prod = {{dmc_pkg::RangeW{1'b0}}, item_i.pitch_range}
               * {{dmc_pkg::RangeW{1'b0}}, dmc_pkg::Div3Mul};
    vol_q3     = vol_prod[dmc_pkg::Div3Shift +: dmc_pkg::ValW];
    pitch_q3   = pitch_prod[dmc_pkg::Div3Shift +: dmc_pkg::ValW];

    note_sum = {1'b0, pitch_q3} + {1'b0, dmc_pkg::NoteOffset};
    note_new = (note_sum > {1'b0, dmc_pkg::ValMax}) ? dmc_pkg::ValMax
                                                    : note_sum[dmc_pkg::ValW-1:0];
    note     = item_i.pitch_error ? held_note_q : note_new;

    // a quotient of 8-bit / 3 never exceeds 127, so 127 - q never underflows
    if (item_i.volume_error || item_i.pitch_error) begin
      vol = '0;
    end else begin
      vol = dmc_pkg::ValMax - vol_q3;
    end

    changed = (note != sent_note_q) || (vol != sent_vol_q);
    if (!changed) begin
      kind = dmc_pkg::MSG_NONE;
    end else if (vol == '0) begin
      kind = dmc_pkg::MSG_OFF;
    end else if (sent_vol_q == '0) begin
      kind = dmc_pkg::MSG_START;
    end else begin
      kind = dmc_pkg::MSG_UPDATE;
    end

    msg_o.kind = kind;
    msg_o.note = note;
    msg_o.vol  = vol;
    msg_o.duty = {{dmc_pkg::ValW{1'b0}}, vol} * {{dmc_pkg::ValW{1'b0}}, vol};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_note_q <= dmc_pkg::NoteReset;
      sent_note_q <= dmc_pkg::SentReset;
      sent_vol_q  <= dmc_pkg::SentReset;
    end else if (accept_i) begin
      held_note_q <= note;
      sent_note_q <= note;
      sent_vol_q  <= vol;
    end
  end

endmodule

// ===== hdl/dmc_serializer.sv =====
// Message register and byte serializer with a registered output slot.
// Depends on dmc_pkg.
module dmc_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dmc_pkg::msg_t      msg_i,
  output logic               load_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmc_pkg::out_item_t out_data_o
);

  logic                      msg_valid_q;
  dmc_pkg::msg_t             msg_q;
  logic [dmc_pkg::IdxW-1:0]  idx_q, last_idx;
  logic                      out_valid_q;
  dmc_pkg::out_item_t        out_q;
  logic                      out_free, emit, is_last;

  assign last_idx     = dmc_pkg::msg_last_idx(msg_q.kind);
  assign out_free     = !out_valid_q || out_ready_i;
  assign emit         = msg_valid_q && out_free;
  assign is_last      = (idx_q == last_idx);
  assign load_ready_o = !msg_valid_q || (out_free && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_i) begin
        msg_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (emit) begin
        if (is_last) begin
          msg_valid_q <= 1'b0;
          idx_q       <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
    if (emit) begin
      out_q.midi_byte  <= dmc_pkg::msg_byte(msg_q.kind, idx_q, msg_q.note, msg_q.vol);
      out_q.byte_valid <= (msg_q.kind != dmc_pkg::MSG_NONE);
      out_q.last_byte  <= is_last;
      out_q.pwm_duty   <= msg_q.duty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a new item only lands when the held message is gone or on its last byte
  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!msg_valid_q || (emit && is_last)))
    else $error("item loaded over an unfinished message");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_q |-> (idx_q <= last_idx))
    else $error("byte index past end of message");

  a_mid_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !is_last) |=> (msg_valid_q && (idx_q == $past(idx_q) + 1'b1)))
    else $error("message dropped before its last byte");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.byte_valid) |-> out_q.last_byte)
    else $error("no-change result not marked last");
`endif

endmodule

// ===== hdl/distance_to_midi_controller_unit.sv =====
// Top level of the distance-to-MIDI controller: calc stage feeding the serializer.
// Depends on dmc_pkg, dmc_calc, dmc_serializer.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (dmc_pkg::in_item_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (dmc_pkg::out_item_t)
//
// An item yields 1, 3, 8 or 13 result items, one per cycle while out_ready_i is high.
// The next item is taken in the cycle its predecessor's last byte moves into the output
// register. The first result passes through the message register and then the output
// register. Reset sets the held note to 0 and the sent note and volume to 127.
// Output stalls hold the output register and back-pressure the input via in_ready_o.
module distance_to_midi_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dmc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmc_pkg::out_item_t out_data_o
);

  logic          accept;
  dmc_pkg::msg_t msg;

  assign accept = in_valid_i && in_ready_o;

  dmc_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .msg_o    (msg)
  );

  dmc_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .msg_i        (msg),
    .load_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== test/tb_top.sv =====
// Testbench for distance_to_midi_controller_unit: drives sensor readings, predicts the
// MIDI bytes and PWM duty of each reading, and checks every result item in order.
// Depends on dmc_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_top;

  localparam int RandomItems = 350;
  localparam int HoldCycles  = 300;
  localparam int EndWait     = 20;
  localparam int CycleLimit  = 200000;

  // Keeps the controller's note/volume history and the bytes still to come.
  class midi_checker;
    dmc_pkg::out_item_t       bytes_due [$];
    logic [dmc_pkg::ValW-1:0] held_note = dmc_pkg::NoteReset;
    logic [dmc_pkg::ValW-1:0] sent_note = dmc_pkg::SentReset;
    logic [dmc_pkg::ValW-1:0] sent_vol  = dmc_pkg::SentReset;
    int                       errors    = 0;
    int                       checked   = 0;
    int                       readings  = 0;
    int                       kind_cnt [4] = '{0, 0, 0, 0};

    function int pending();
      return bytes_due.size();
    endfunction

    function void note_reading(dmc_pkg::in_item_t it);
      logic [dmc_pkg::RangeW-1:0] q;
      logic [dmc_pkg::RangeW-1:0] n;
      logic [dmc_pkg::ValW-1:0]   vol;
      logic [dmc_pkg::DutyW-1:0]  duty;
      logic [7:0]                 msg [$];
      logic [7:0]                 tail [8];
      dmc_pkg::msg_kind_e         kind;
      dmc_pkg::out_item_t         r;
      vol = '0;
      if (!it.volume_error) begin
        q   = it.volume_range / 3;
        vol = (q > dmc_pkg::ValMax) ? '0 : dmc_pkg::ValMax - q[dmc_pkg::ValW-1:0];
      end
      // a pitch error keeps the old note and mutes
      if (!it.pitch_error) begin
        n         = it.pitch_range / 3 + dmc_pkg::NoteOffset;
        held_note = (n > dmc_pkg::ValMax) ? dmc_pkg::ValMax : n[dmc_pkg::ValW-1:0];
      end else begin
        vol = '0;
      end
      duty = dmc_pkg::DutyW'(vol) * dmc_pkg::DutyW'(vol);

      if (held_note == sent_note && vol == sent_vol) kind = dmc_pkg::MSG_NONE;
      else if (vol == '0)                            kind = dmc_pkg::MSG_OFF;
      else if (sent_vol == '0)                       kind = dmc_pkg::MSG_START;
      else                                           kind = dmc_pkg::MSG_UPDATE;

      case (kind)
        dmc_pkg::MSG_OFF: begin
          msg = '{dmc_pkg::MidiCtrlChg, dmc_pkg::MidiAllOff, dmc_pkg::MidiZero};
        end
        dmc_pkg::MSG_START, dmc_pkg::MSG_UPDATE: begin
          if (kind == dmc_pkg::MSG_START) begin
            msg = '{dmc_pkg::MidiProgChg, dmc_pkg::MidiProgNum, dmc_pkg::MidiNoteOn,
                    dmc_pkg::MidiMidVal, dmc_pkg::MidiMidVal};
          end
          tail = '{dmc_pkg::MidiPitch, {1'b0, held_note}, {1'b0, held_note},
                   dmc_pkg::MidiCtrlChg, dmc_pkg::MidiVolMsb, {1'b0, vol},
                   dmc_pkg::MidiVolLsb, {1'b0, vol}};
          foreach (tail[k]) msg.push_back(tail[k]);
        end
        default: ;
      endcase

      sent_note = held_note;
      sent_vol  = vol;
      kind_cnt[kind]++;
      readings++;

      if (msg.size() == 0) begin
        r = '{dmc_pkg::MidiZero, 1'b0, 1'b1, duty};
        bytes_due.push_back(r);
      end else begin
        foreach (msg[k]) begin
          r.midi_byte  = msg[k];
          r.byte_valid = 1'b1;
          r.last_byte  = (k == msg.size() - 1);
          r.pwm_duty   = duty;
          bytes_due.push_back(r);
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("tb_top: error: %s", what);
    endtask

    task check_byte(dmc_pkg::out_item_t got);
      dmc_pkg::out_item_t want;
      if (bytes_due.size() == 0) begin
        report($sformatf("result %h arrived with nothing pending", got));
      end else begin
        want = bytes_due.pop_front();
        checked++;
        if (got.midi_byte !== want.midi_byte)
          report($sformatf("result %0d midi_byte %h, want %h",
                           checked, got.midi_byte, want.midi_byte));
        if (got.byte_valid !== want.byte_valid)
          report($sformatf("result %0d byte_valid %b, want %b",
                           checked, got.byte_valid, want.byte_valid));
        if (got.last_byte !== want.last_byte)
          report($sformatf("result %0d last_byte %b, want %b",
                           checked, got.last_byte, want.last_byte));
        if (got.pwm_duty !== want.pwm_duty)
          report($sformatf("result %0d pwm_duty %0d, want %0d",
                           checked, got.pwm_duty, want.pwm_duty));
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  dmc_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  dmc_pkg::out_item_t out_data_o;

  logic      steady  = 1'b0;  // no idling on either side
  logic      hold_go = 1'b0;  // asks the receiver for its long stall

  midi_checker sb = new;

  // volume_range, volume_error, pitch_range, pitch_error
  dmc_pkg::in_item_t directed_set [20] = '{
    {8'd0,   1'b0, 8'd255, 1'b0},  // full volume, top note: update from reset
    {8'd0,   1'b0, 8'd255, 1'b0},  // unchanged: silent item
    {8'd255, 1'b0, 8'd255, 1'b0},  // lowest volume
    {8'd255, 1'b1, 8'd0,   1'b0},  // volume sensor error: all notes off
    {8'd255, 1'b1, 8'd0,   1'b0},  // still muted, same note: silent
    {8'd3,   1'b0, 8'd0,   1'b0},  // unmute: start message
    {8'd3,   1'b0, 8'd0,   1'b1},  // pitch error mutes, note held
    {8'd3,   1'b1, 8'd255, 1'b1},  // both errors while muted: silent
    {8'd0,   1'b0, 8'd1,   1'b0},  // unmute again
    {8'd1,   1'b0, 8'd2,   1'b0},  // same after division: silent
    {8'd2,   1'b0, 8'd3,   1'b0},  // note steps up
    {8'd3,   1'b0, 8'd3,   1'b0},  // volume steps down
    {8'd170, 1'b0, 8'd128, 1'b0},
    {8'h55,  1'b0, 8'hAA,  1'b0},
    {8'hAA,  1'b0, 8'h55,  1'b0},
    {8'd255, 1'b1, 8'd255, 1'b1},  // both errors from sounding: off
    {8'd0,   1'b1, 8'd200, 1'b0},  // muted, new note: off again
    {8'd254, 1'b0, 8'd254, 1'b0},  // start
    {8'd254, 1'b0, 8'd253, 1'b0},  // silent
    {8'd0,   1'b0, 8'd0,   1'b0}   // lowest note, loudest
  };

  distance_to_midi_controller_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic send_item(dmc_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reading(it);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every pending byte
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // mostly fresh readings, with repeats, near repeats and sensor errors mixed in
  function automatic dmc_pkg::in_item_t next_reading(dmc_pkg::in_item_t prev);
    dmc_pkg::in_item_t it;
    int                pick;
    pick            = $urandom_range(99);
    it.volume_range = 8'($urandom_range(255));
    it.pitch_range  = 8'($urandom_range(255));
    it.volume_error = 1'b0;
    it.pitch_error  = 1'b0;
    if (pick < 20) begin
      it = prev;
    end else if (pick < 32) begin
      it.volume_error = 1'b1;
    end else if (pick < 44) begin
      it.pitch_error = 1'b1;
    end else if (pick < 48) begin
      it.volume_error = 1'b1;
      it.pitch_error  = 1'b1;
    end else if (pick < 70) begin
      it.volume_range = prev.volume_range ^ 8'($urandom_range(7));
      it.pitch_range  = prev.pitch_range ^ 8'($urandom_range(7));
    end
    return it;
  endfunction

  // receiver: checks accepted results and decides ready for the next cycle
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_byte(out_data_o);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: timeout after %0d cycles, %0d results pending",
             cycles, sb.pending());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    dmc_pkg::in_item_t it;
    dmc_pkg::in_item_t prev;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_set[i]) begin
      sender_gap();
      send_item(directed_set[i]);
    end
    drain();

    prev = directed_set[19];
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 100) steady <= 1'b1;
      if (i == 160) steady <= 1'b0;
      if (i == 220) hold_go <= 1'b1;
      if (i == 280) drain();
      it = next_reading(prev);
      if (i < 100 || i >= 160) sender_gap();
      send_item(it);
      prev = it;
    end
    drain();
    repeat (EndWait) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("tb_top: %0d readings, %0d results checked: %0d silent, %0d all-off,",
             sb.readings, sb.checked, sb.kind_cnt[dmc_pkg::MSG_NONE],
             sb.kind_cnt[dmc_pkg::MSG_OFF]);
    $display("tb_top: %0d start, %0d update; sensor errors, held notes, a %0d-cycle stall",
             sb.kind_cnt[dmc_pkg::MSG_START], sb.kind_cnt[dmc_pkg::MSG_UPDATE], HoldCycles);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dmc_pkg.sv
hdl/dmc_calc.sv
hdl/dmc_serializer.sv
hdl/distance_to_midi_controller_unit.sv
test/tb_top.sv
